@@ src/dmsp_pkg.sv @@
// Package for the DHCP message stream parser: parse phases, result kinds,
// header layout constants, the result record and the queue status record.
// No dependencies.
package dmsp_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_COOKIE = 3'd2;
   localparam logic [2:0] PH_CODE   = 3'd3;
   localparam logic [2:0] PH_LEN    = 3'd4;
   localparam logic [2:0] PH_VAL    = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;

   localparam logic [2:0] KIND_FIELD     = 3'd0;
   localparam logic [2:0] KIND_ARRAY     = 3'd1;
   localparam logic [2:0] KIND_OPT_START = 3'd2;
   localparam logic [2:0] KIND_OPT_BYTE  = 3'd3;
   localparam logic [2:0] KIND_END       = 3'd4;
   localparam logic [2:0] KIND_COOKIE    = 3'd5;

   localparam logic [3:0] FID_OP     = 4'd0;
   localparam logic [3:0] FID_HTYPE  = 4'd1;
   localparam logic [3:0] FID_HLEN   = 4'd2;
   localparam logic [3:0] FID_HOPS   = 4'd3;
   localparam logic [3:0] FID_XID    = 4'd4;
   localparam logic [3:0] FID_SECS   = 4'd5;
   localparam logic [3:0] FID_FLAGS  = 4'd6;
   localparam logic [3:0] FID_CIADDR = 4'd7;
   localparam logic [3:0] FID_YIADDR = 4'd8;
   localparam logic [3:0] FID_SIADDR = 4'd9;
   localparam logic [3:0] FID_GIADDR = 4'd10;
   localparam logic [3:0] FID_CHADDR = 4'd11;
   localparam logic [3:0] FID_SNAME  = 4'd12;
   localparam logic [3:0] FID_FILE   = 4'd13;

   localparam logic [15:0] CHADDR_START = 16'd28;
   localparam logic [15:0] SNAME_START  = 16'd44;
   localparam logic [15:0] FILE_START   = 16'd108;
   localparam logic [15:0] HEADER_BYTES = 16'd236;
   localparam logic [15:0] COOKIE_END   = 16'd240;
   localparam logic [15:0] COOKIE_BYTES = 16'd4;
   localparam logic [31:0] COOKIE_WORD  = 32'h6382_5363;
   localparam logic [7:0]  OPT_PAD      = 8'd0;
   localparam logic [7:0]  OPT_END      = 8'd255;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  field_id;
      logic [31:0] value;
      logic [7:0]  byte_index;
      logic [7:0]  option_code;
      logic [7:0]  option_length;
      logic [15:0] option_offset;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] fid;
   } scalar_type;

   // Last byte of each scalar header field
   function automatic scalar_type scalar_end(input logic [4:0] pos);
      scalar_type r;
      r.hit = 1'b1;
      unique case (pos)
         5'd0:    r.fid = FID_OP;
         5'd1:    r.fid = FID_HTYPE;
         5'd2:    r.fid = FID_HLEN;
         5'd3:    r.fid = FID_HOPS;
         5'd7:    r.fid = FID_XID;
         5'd9:    r.fid = FID_SECS;
         5'd11:   r.fid = FID_FLAGS;
         5'd15:   r.fid = FID_CIADDR;
         5'd19:   r.fid = FID_YIADDR;
         5'd23:   r.fid = FID_SIADDR;
         5'd27:   r.fid = FID_GIADDR;
         default: begin
            r.hit = 1'b0;
            r.fid = FID_OP;
         end
      endcase
      return r;
   endfunction

endpackage

@@ src/dmsp_if.sv @@
// Channel interfaces of the DHCP message stream parser: byte request and
// parse result. No dependencies.
interface dmsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_message;
   modport source (output valid, output data_byte, output start_of_message, input ready);
   modport sink (input valid, input data_byte, input start_of_message, output ready);
endinterface

interface dmsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [3:0]  field_id;
   logic [31:0] value;
   logic [7:0]  byte_index;
   logic [7:0]  option_code;
   logic [7:0]  option_length;
   logic [15:0] option_offset;
   modport source (output valid, output kind, output field_id, output value,
                   output byte_index, output option_code, output option_length,
                   output option_offset, input ready);
   modport sink (input valid, input kind, input field_id, input value,
                 input byte_index, input option_code, input option_length,
                 input option_offset, output ready);
endinterface

@@ src/dmsp_front.sv @@
// Front end: accepts message bytes, tracks the parse phase and classifies
// each beat into at most one result record. Depends on dmsp_pkg, dmsp_if.
module dmsp_front
   import dmsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dmsp_req_if.sink    req_ch,
   input  qstat_type   qstat,
   output logic        push,
   output result_type  push_data
);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  rem_ff, rem_in;

   logic        beat;
   logic        emit;
   result_type  res;
   logic [2:0]  ph;
   logic [15:0] pos;
   logic [31:0] acc;
   logic [7:0]  code, len, rem, b, idx;
   logic [15:0] pos_inc;
   logic [31:0] acc_sh;
   scalar_type  sc;

   assign req_ch.ready = !qstat.full;
   assign beat = req_ch.valid && req_ch.ready;
   assign b    = req_ch.data_byte;

   always_comb begin
      ph   = req_ch.start_of_message ? PH_HEADER : phase_ff;
      pos  = req_ch.start_of_message ? 16'd0 : pos_ff;
      acc  = req_ch.start_of_message ? 32'd0 : acc_ff;
      code = req_ch.start_of_message ? 8'd0 : code_ff;
      len  = req_ch.start_of_message ? 8'd0 : len_ff;
      rem  = req_ch.start_of_message ? 8'd0 : rem_ff;
      pos_inc = pos + 16'd1;
      acc_sh  = {acc[23:0], b};
      idx     = len - rem;
      sc      = scalar_end(pos[4:0]);

      phase_in = ph;
      pos_in   = pos;
      acc_in   = acc;
      code_in  = code;
      len_in   = len;
      rem_in   = rem;
      emit     = 1'b0;
      res      = '0;

      unique case (ph)
         PH_HEADER: begin
            if (pos >= FILE_START) begin
               emit = 1'b1;
               res.kind = KIND_ARRAY;
               res.field_id = FID_FILE;
               res.value = {24'd0, b};
               res.byte_index = 8'(pos - FILE_START);
            end else if (pos >= SNAME_START) begin
               emit = 1'b1;
               res.kind = KIND_ARRAY;
               res.field_id = FID_SNAME;
               res.value = {24'd0, b};
               res.byte_index = 8'(pos - SNAME_START);
            end else if (pos >= CHADDR_START) begin
               emit = 1'b1;
               res.kind = KIND_ARRAY;
               res.field_id = FID_CHADDR;
               res.value = {24'd0, b};
               res.byte_index = 8'(pos - CHADDR_START);
            end else begin
               acc_in = acc_sh;
               if (sc.hit) begin
                  emit = 1'b1;
                  res.kind = KIND_FIELD;
                  res.field_id = sc.fid;
                  res.value = acc_sh;
                  acc_in = 32'd0;
               end
            end
            pos_in = pos_inc;
            if (pos_inc >= HEADER_BYTES) begin
               phase_in = PH_COOKIE;
               acc_in = 32'd0;
            end
         end
         PH_COOKIE: begin
            acc_in = acc_sh;
            pos_in = pos_inc;
            if (pos_inc >= COOKIE_END) begin
               if (acc_sh != COOKIE_WORD) begin
                  emit = 1'b1;
                  res.kind = KIND_COOKIE;
                  res.value = acc_sh;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_CODE;
                  pos_in = COOKIE_BYTES;
                  acc_in = 32'd0;
               end
            end
         end
         PH_CODE: begin
            pos_in = pos_inc;
            if (b == OPT_END) begin
               emit = 1'b1;
               res.kind = KIND_END;
               res.option_code = OPT_END;
               res.option_offset = pos;
               phase_in = PH_DONE;
            end else if (b != OPT_PAD) begin
               code_in = b;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            len_in = b;
            rem_in = b;
            pos_in = pos_inc;
            emit = 1'b1;
            res.kind = KIND_OPT_START;
            res.option_code = code;
            res.option_length = b;
            res.option_offset = pos_inc;
            phase_in = (b == 8'd0) ? PH_CODE : PH_VAL;
         end
         PH_VAL: begin
            emit = 1'b1;
            res.kind = KIND_OPT_BYTE;
            res.value = {24'd0, b};
            res.byte_index = idx;
            res.option_code = code;
            res.option_length = len;
            res.option_offset = pos - {8'd0, idx};
            pos_in = pos_inc;
            rem_in = rem - 8'd1;
            if (rem == 8'd1) begin
               phase_in = PH_CODE;
            end
         end
         default: begin
            phase_in = ph;
         end
      endcase
   end

   assign push      = beat && emit;
   assign push_data = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= 16'd0;
         acc_ff   <= 32'd0;
         code_ff  <= 8'd0;
         len_ff   <= 8'd0;
         rem_ff   <= 8'd0;
      end else if (beat) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         code_ff  <= code_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
      end
   end

`ifndef SYNTH
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE || phase_ff == PH_IDLE) && !req_ch.start_of_message |-> !push)
      else $error("result pushed outside a message");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("push into full queue");
   a_val_remaining: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VAL |-> rem_ff != 8'd0)
      else $error("value phase with nothing remaining");
`endif

endmodule

@@ src/dmsp_queue.sv @@
// Short result queue between the parse front end and the output stage.
// Depends on dmsp_pkg.
module dmsp_queue
   import dmsp_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  result_type  push_data,
   input  logic        pop,
   output result_type  pop_data,
   output qstat_type   qstat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   result_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign qstat.full  = count_ff == CNT_W'(DEPTH);
   assign qstat.empty = count_ff == '0;
   assign pop_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop)
      else $error("pop from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance");
`endif

endmodule

@@ src/dmsp_back.sv @@
// Output stage: drains the result queue into a registered response beat.
// Depends on dmsp_pkg, dmsp_if.
module dmsp_back
   import dmsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  qstat_type   qstat,
   input  result_type  pop_data,
   output logic        pop,
   dmsp_rsp_if.source  rsp_ch
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign pop      = !qstat.empty && (!valid_ff || rsp_ch.ready);
   assign valid_in = pop || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= pop_data;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.kind          = data_ff.kind;
   assign rsp_ch.field_id      = data_ff.field_id;
   assign rsp_ch.value         = data_ff.value;
   assign rsp_ch.byte_index    = data_ff.byte_index;
   assign rsp_ch.option_code   = data_ff.option_code;
   assign rsp_ch.option_length = data_ff.option_length;
   assign rsp_ch.option_offset = data_ff.option_offset;

endmodule

@@ src/dhcp_message_stream_parser_top.sv @@
// Top level of the DHCP message stream parser: front end, result queue and
// output stage. Depends on dmsp_pkg, dmsp_if, dmsp_front, dmsp_queue, dmsp_back.
//
//   port    dir  handshake    beat carries
//   req_ch  in   valid/ready  data_byte, start_of_message
//   rsp_ch  out  valid/ready  kind, field_id, value, byte_index, option_*
//
// One byte is taken every cycle while the queue has room; each byte yields
// at most one result, so the sustained rate is one byte per cycle while rsp_ch
// does not stall. A result reaches rsp_ch through the queue storage and then
// the output register. Stalls on rsp_ch fill the QUEUE_DEPTH-entry queue
// before req_ch.ready drops. Synchronous reset returns the parse to idle.
module dhcp_message_stream_parser_top
   import dmsp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dmsp_req_if.sink   req_ch,
   dmsp_rsp_if.source rsp_ch
);

   logic       push, pop;
   result_type push_data, pop_data;
   qstat_type  qstat;

   dmsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   dmsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   dmsp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ tb/testbench.sv @@
// Testbench for dhcp_message_stream_parser_top: sends DHCP messages byte by byte,
// predicts every parse result in step and checks each result beat field by field.
// Depends on dmsp_pkg, dmsp_if and the parser RTL.
module testbench;
   import dmsp_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       som;
   } beat_type;

   typedef enum logic [1:0] {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_type;

   logic        clock;
   logic        reset;
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned mismatch_count;

   beat_type    stream[$];
   result_type  pending_results[$];
   result_type  want;

   logic [2:0]  msg_phase;
   logic [15:0] msg_pos;
   logic [31:0] field_acc;
   logic [7:0]  opt_code;
   logic [7:0]  opt_len;
   logic [7:0]  opt_left;

   dmsp_req_if req_ch ();
   dmsp_rsp_if rsp_ch ();

   dhcp_message_stream_parser_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task predict_parse(input logic [7:0] b, input logic som);
      result_type  r;
      logic [15:0] rel;
      logic [7:0]  idx;
      logic [3:0]  fid;
      logic        hit;
      r = '0;
      if (som) begin
         msg_phase = PH_HEADER;
         msg_pos   = '0;
         field_acc = '0;
         opt_code  = '0;
         opt_len   = '0;
         opt_left  = '0;
      end
      case (msg_phase)
         PH_HEADER: begin
            if (msg_pos >= CHADDR_START) begin
               r.kind  = KIND_ARRAY;
               r.value = {24'd0, b};
               if (msg_pos >= FILE_START) begin
                  r.field_id = FID_FILE;
                  rel = msg_pos - FILE_START;
               end else if (msg_pos >= SNAME_START) begin
                  r.field_id = FID_SNAME;
                  rel = msg_pos - SNAME_START;
               end else begin
                  r.field_id = FID_CHADDR;
                  rel = msg_pos - CHADDR_START;
               end
               r.byte_index = rel[7:0];
               pending_results.push_back(r);
            end else begin
               field_acc = {field_acc[23:0], b};
               hit = 1'b1;
               fid = FID_OP;
               case (msg_pos)
                  16'd0:   fid = FID_OP;
                  16'd1:   fid = FID_HTYPE;
                  16'd2:   fid = FID_HLEN;
                  16'd3:   fid = FID_HOPS;
                  16'd7:   fid = FID_XID;
                  16'd9:   fid = FID_SECS;
                  16'd11:  fid = FID_FLAGS;
                  16'd15:  fid = FID_CIADDR;
                  16'd19:  fid = FID_YIADDR;
                  16'd23:  fid = FID_SIADDR;
                  16'd27:  fid = FID_GIADDR;
                  default: hit = 1'b0;
               endcase
               if (hit) begin
                  r.kind     = KIND_FIELD;
                  r.field_id = fid;
                  r.value    = field_acc;
                  pending_results.push_back(r);
                  field_acc = '0;
               end
            end
            msg_pos = msg_pos + 16'd1;
            if (msg_pos >= HEADER_BYTES) begin
               msg_phase = PH_COOKIE;
               field_acc = '0;
            end
         end
         PH_COOKIE: begin
            field_acc = {field_acc[23:0], b};
            msg_pos   = msg_pos + 16'd1;
            if (msg_pos >= COOKIE_END) begin
               if (field_acc != COOKIE_WORD) begin
                  r.kind  = KIND_COOKIE;
                  r.value = field_acc;
                  pending_results.push_back(r);
                  msg_phase = PH_DONE;
               end else begin
                  msg_phase = PH_CODE;
                  msg_pos   = COOKIE_BYTES;
                  field_acc = '0;
               end
            end
         end
         PH_CODE: begin
            if (b == OPT_PAD) begin
               msg_pos = msg_pos + 16'd1;
            end else if (b == OPT_END) begin
               r.kind          = KIND_END;
               r.option_code   = OPT_END;
               r.option_offset = msg_pos;
               pending_results.push_back(r);
               msg_pos   = msg_pos + 16'd1;
               msg_phase = PH_DONE;
            end else begin
               opt_code  = b;
               msg_pos   = msg_pos + 16'd1;
               msg_phase = PH_LEN;
            end
         end
         PH_LEN: begin
            opt_len  = b;
            opt_left = b;
            msg_pos  = msg_pos + 16'd1;
            r.kind          = KIND_OPT_START;
            r.option_code   = opt_code;
            r.option_length = opt_len;
            r.option_offset = msg_pos;
            pending_results.push_back(r);
            msg_phase = (b == 8'd0) ? PH_CODE : PH_VAL;
         end
         PH_VAL: begin
            idx = opt_len - opt_left;
            r.kind          = KIND_OPT_BYTE;
            r.value         = {24'd0, b};
            r.byte_index    = idx;
            r.option_code   = opt_code;
            r.option_length = opt_len;
            r.option_offset = msg_pos - {8'd0, idx};
            pending_results.push_back(r);
            msg_pos  = msg_pos + 16'd1;
            opt_left = opt_left - 8'd1;
            if (opt_left == 8'd0)
               msg_phase = PH_CODE;
         end
         default: ;
      endcase
   endtask

   task send_byte(input logic [7:0] data, input logic som);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.data_byte        <= data;
      req_ch.start_of_message <= som;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      predict_parse(data, som);
   endtask

   task send_stream;
      foreach (stream[i])
         send_byte(stream[i].data, stream[i].som);
      stream.delete();
   endtask

   task push_byte(input logic [7:0] data, input logic som);
      beat_type b;
      b.data = data;
      b.som  = som;
      stream.push_back(b);
   endtask

   task push_noise(input int unsigned count);
      repeat (count)
         push_byte(8'($urandom), 1'b0);
   endtask

   task push_header(input fill_type fill);
      logic [7:0] d;
      for (int i = 0; i < HEADER_BYTES; i++) begin
         case (fill)
            FILL_ZEROS: d = 8'h00;
            FILL_ONES:  d = 8'hFF;
            default:    d = 8'($urandom);
         endcase
         push_byte(d, i == 0);
      end
   endtask

   task push_cookie(input logic [31:0] cookie);
      push_byte(cookie[31:24], 1'b0);
      push_byte(cookie[23:16], 1'b0);
      push_byte(cookie[15:8], 1'b0);
      push_byte(cookie[7:0], 1'b0);
   endtask

   task push_option(input logic [7:0] code, input logic [7:0] len);
      push_byte(code, 1'b0);
      push_byte(len, 1'b0);
      repeat (len)
         push_byte(8'($urandom), 1'b0);
   endtask

   task push_options(input int unsigned count, input int unsigned max_len,
                     input logic with_end);
      repeat (count) begin
         if ($urandom_range(4) == 0)
            push_byte(OPT_PAD, 1'b0);
         else
            push_option(8'($urandom_range(1, 254)), 8'($urandom_range(0, max_len)));
      end
      if (with_end)
         push_byte(OPT_END, 1'b0);
   endtask

   task truncate_stream(input int unsigned keep);
      while (stream.size() > keep)
         void'(stream.pop_back());
   endtask

   function automatic logic [31:0] bad_cookie;
      return COOKIE_WORD ^ (32'd1 << $urandom_range(31));
   endfunction

   task check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result beat, expected none actual kind %0h value %0h",
                     $time, rsp_ch.kind, rsp_ch.value);
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_ch.kind));
            check_field("field_id", 32'(want.field_id), 32'(rsp_ch.field_id));
            check_field("value", want.value, rsp_ch.value);
            check_field("byte_index", 32'(want.byte_index), 32'(rsp_ch.byte_index));
            check_field("option_code", 32'(want.option_code), 32'(rsp_ch.option_code));
            check_field("option_length", 32'(want.option_length),
                        32'(rsp_ch.option_length));
            check_field("option_offset", 32'(want.option_offset),
                        32'(rsp_ch.option_offset));
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task test_bytes_before_start;
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_noise(4);
      send_stream();
   endtask

   task test_header_extremes;
      push_header(FILL_ONES);
      push_cookie(COOKIE_WORD);
      push_byte(OPT_PAD, 1'b0);
      push_option(8'd1, 8'd0);
      push_option(8'd254, 8'd32);
      push_option(8'h80, 8'd1);
      push_byte(OPT_PAD, 1'b0);
      push_byte(OPT_END, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      send_stream();
   endtask

   task test_cookie_mismatch;
      push_header(FILL_ZEROS);
      push_cookie(bad_cookie());
      push_byte(8'd53, 1'b0);
      push_byte(8'd1, 1'b0);
      push_byte(OPT_END, 1'b0);
      send_stream();
   endtask

   task test_restart_mid_message;
      push_header(FILL_RANDOM);
      truncate_stream(20);
      push_header(FILL_RANDOM);
      push_cookie(COOKIE_WORD);
      push_option(8'd53, 8'd1);
      truncate_stream(stream.size() - 1);
      send_stream();
   endtask

   task test_random_messages(input int unsigned byte_target);
      int unsigned sent;
      int unsigned pick;
      sent = 0;
      while (sent < byte_target) begin
         push_noise($urandom_range(0, 3));
         pick = $urandom_range(99);
         push_header(FILL_RANDOM);
         push_cookie((pick < 15) ? bad_cookie() : COOKIE_WORD);
         push_options($urandom_range(0, 6), 8, $urandom_range(3) != 0);
         push_noise($urandom_range(0, 4));
         if (pick >= 85)
            truncate_stream($urandom_range(1, stream.size() - 1));
         sent += stream.size();
         send_stream();
      end
   endtask

   initial begin
      msg_phase      = PH_IDLE;
      msg_pos        = '0;
      field_acc      = '0;
      opt_code       = '0;
      opt_len        = '0;
      opt_left       = '0;
      mismatch_count = 0;
      reset                   <= 1'b1;
      req_ch.valid            <= 1'b0;
      req_ch.data_byte        <= 8'h00;
      req_ch.start_of_message <= 1'b0;
      sender_idle_pct    = 26;
      receiver_stall_pct = 51;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_bytes_before_start();
      test_header_extremes();

      sender_idle_pct    = 51;
      receiver_stall_pct = 26;
      test_cookie_mismatch();
      test_restart_mid_message();

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      test_random_messages(1);

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS dhcp_message_stream_parser_top");
      else
         $display("FAIL dhcp_message_stream_parser_top");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL dhcp_message_stream_parser_top");
      $finish;
   end

endmodule

@@ filelist.f @@
src/dmsp_pkg.sv
src/dmsp_if.sv
src/dmsp_front.sv
src/dmsp_queue.sv
src/dmsp_back.sv
src/dhcp_message_stream_parser_top.sv
tb/testbench.sv
